[rtl/assert_macros.svh]
// Assertion macros of the convolution block, used by its top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Consequent must hold in the same cycle as the antecedent.
`define RCS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define RCS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define RCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

[rtl/rcs_pkg.sv]
// Shared types and constants of the 3x3 RGB convolution block.
package rcs_pkg;

	// one RGB pixel, red in the top byte
	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_t;

	// control of one beat between pipeline stages
	typedef struct packed {
		logic valid;
		logic emit;
	} stage_ctl_t;

	// result beats still inside the filter pipeline
	typedef struct packed {
		logic emit_s2;
		logic emit_s3;
	} filt_status_t;

	// configuration register file
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 13;
	localparam int MODE_W       = 2;
	localparam int WIDTH_REG_W  = 11;
	localparam int HEIGHT_REG_W = 13;

	localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

	localparam logic [MODE_W-1:0]       MODE_SHARPEN       = 2'd1;
	localparam logic [MODE_W-1:0]       MODE_RESET         = 2'd0;
	localparam logic [WIDTH_REG_W-1:0]  IMAGE_WIDTH_RESET  = 11'd640;
	localparam logic [HEIGHT_REG_W-1:0] IMAGE_HEIGHT_RESET = 13'd480;

	// smallest frame side, and the lag of the window's first column and line behind the newest pixel
	localparam int MIN_DIM = 3;
	localparam int WIN_LAG = 2;

	// output queue
	localparam int OQ_DEPTH = 8;
	localparam int OQ_AW    = $clog2(OQ_DEPTH);
	localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

endpackage

[rtl/rgb_conv3x3_smooth_sharpen_top.sv]
// Top level of the streaming 3x3 RGB smoothing / sharpening filter.
//
// Input channel: one raster-order RGB pixel per beat (in_valid / in_stall).
// Output channel: one filtered pixel with its destination (dest_x, dest_y)
// per beat (out_valid / out_stall), for every window whose centre is an
// interior pixel of the frame; border centres give no beat.
// Configuration: cfg_valid / cfg_ready write of filter_mode (0), image_width
// (1) or image_height (2); cfg_ready is always high. Write only while idle.
// Throughput: one pixel per clock while in_stall is low, set by the line store
// RAM, which takes one read at the arriving column and one write-back of the
// previous column each cycle.
// Path: an accepted pixel passes the stage 1 registers with the line store
// read, the window shift, the registered kernel sums and the output queue.
// Stalling: results wait in an 8-entry output queue; in_stall rises when the
// queue plus the results still in the pipeline would fill it, so nothing is
// dropped and the pipeline never stops mid-flight.
// Reset: counters start at column 0 / line 0, registers return to mode 0,
// 640 x 480, the queue empties. The line store RAM is not cleared; no
// clearing pass is needed as unwritten entries never reach a result.
`include "assert_macros.svh"

module rgb_conv3x3_smooth_sharpen_top #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 4096,
	localparam int CW = $clog2(MAX_WIDTH),
	localparam int LW = $clog2(MAX_HEIGHT)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [7:0]                     in_red,
	input  logic [7:0]                     in_green,
	input  logic [7:0]                     in_blue,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [7:0]                     out_red,
	output logic [7:0]                     out_green,
	output logic [7:0]                     out_blue,
	output logic [CW-1:0]                  dest_x,
	output logic [LW-1:0]                  dest_y,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [rcs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rcs_pkg::CFG_DATA_W-1:0] cfg_data
);

	import rcs_pkg::*;

	localparam int WW  = $clog2(MAX_WIDTH + 1);
	localparam int HW  = $clog2(MAX_HEIGHT + 1);
	localparam int DW  = 24 + CW + LW;
	localparam int CRW = OQ_CNT_W + 1;

	logic [MODE_W-1:0]       cfg_mode_q;
	logic [WIDTH_REG_W-1:0]  cfg_width_q;
	logic [HEIGHT_REG_W-1:0] cfg_height_q;
	logic [CW-1:0]           col_q;
	logic [LW-1:0]           line_q;
	logic [WW-1:0]           w_eff;
	logic [HW-1:0]           h_eff;
	logic                    col_wrap, line_wrap, emit_in, in_acc;

	stage_ctl_t              ctl_s1;
	pixel_t                  px_s1;
	logic [CW-1:0]           col_s1;
	logic [LW-1:0]           line_s1;
	logic [47:0]             ls_rd;
	pixel_t                  ls_up, ls_mid;

	logic                    res_valid;
	pixel_t                  res_pix;
	logic [CW-1:0]           res_dx;
	logic [LW-1:0]           res_dy;
	filt_status_t            status;

	logic [DW-1:0]           q_out;
	logic [OQ_CNT_W-1:0]     fifo_count;
	logic [CRW-1:0]          credit;
	logic                    pop;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_mode_q   <= MODE_RESET;
			cfg_width_q  <= IMAGE_WIDTH_RESET;
			cfg_height_q <= IMAGE_HEIGHT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_FILTER_MODE:  cfg_mode_q   <= cfg_data[MODE_W-1:0];
				REG_IMAGE_WIDTH:  cfg_width_q  <= cfg_data[WIDTH_REG_W-1:0];
				REG_IMAGE_HEIGHT: cfg_height_q <= cfg_data[HEIGHT_REG_W-1:0];
				default: ;
			endcase
		end
	end

	// frame size held within the supported range
	always_comb begin
		if (32'(cfg_width_q) < MIN_DIM) begin
			w_eff = WW'(MIN_DIM);
		end else if (32'(cfg_width_q) > MAX_WIDTH) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(cfg_width_q);
		end
		if (32'(cfg_height_q) < MIN_DIM) begin
			h_eff = HW'(MIN_DIM);
		end else if (32'(cfg_height_q) > MAX_HEIGHT) begin
			h_eff = HW'(MAX_HEIGHT);
		end else begin
			h_eff = HW'(cfg_height_q);
		end
	end

	// position decode of the arriving pixel
	assign col_wrap  = 32'(col_q) >= 32'(w_eff) - 1;
	assign line_wrap = 32'(line_q) >= 32'(h_eff) - 1;
	assign emit_in   = (32'(col_q) >= WIN_LAG) && (32'(line_q) >= WIN_LAG) &&
	                   (32'(col_q) < 32'(w_eff)) && (32'(line_q) < 32'(h_eff));

	// credit: queue fill plus result beats in flight
	assign credit   = CRW'(fifo_count) + CRW'(ctl_s1.valid & ctl_s1.emit) +
	                  CRW'(status.emit_s2) + CRW'(status.emit_s3);
	assign in_stall = (credit >= CRW'(OQ_DEPTH));
	assign in_acc   = in_valid && !in_stall;

	// column and line counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			line_q <= '0;
		end else if (in_acc) begin
			if (col_wrap) begin
				col_q  <= '0;
				line_q <= line_wrap ? '0 : line_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// stage 1: line store read in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1.valid <= in_acc;
			ctl_s1.emit  <= emit_in;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			px_s1   <= '{red: in_red, green: in_green, blue: in_blue};
			col_s1  <= col_q;
			line_s1 <= line_q;
		end
	end

	// line store: word holds the upper and middle line pixels of a column
	rcs_line_store #(
		.DEPTH (MAX_WIDTH),
		.DW    (48)
	) u_line_store (
		.clk     (clk),
		.rd_en   (in_acc),
		.rd_addr (col_q),
		.rd_data (ls_rd),
		.wr_en   (ctl_s1.valid),
		.wr_addr (col_s1),
		.wr_data ({ls_mid, px_s1})
	);

	assign ls_up  = ls_rd[47:24];
	assign ls_mid = ls_rd[23:0];

	// window and kernel
	rcs_filter #(
		.CW (CW),
		.LW (LW)
	) u_filter (
		.clk       (clk),
		.arst_n    (arst_n),
		.col_ctl   (ctl_s1),
		.col_up    (ls_up),
		.col_mid   (ls_mid),
		.col_px    (px_s1),
		.col_dx    (col_s1 - CW'(WIN_LAG)),
		.col_dy    (line_s1 - LW'(WIN_LAG)),
		.sharpen   (cfg_mode_q == MODE_SHARPEN),
		.res_valid (res_valid),
		.res_pix   (res_pix),
		.res_dx    (res_dx),
		.res_dy    (res_dy),
		.status    (status)
	);

	// output queue
	assign pop = out_valid && !out_stall;

	rcs_out_queue #(
		.DW (DW)
	) u_out_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data ({res_pix, res_dx, res_dy}),
		.pop       (pop),
		.pop_data  (q_out),
		.not_empty (out_valid),
		.count     (fifo_count)
	);

	assign out_red   = q_out[DW-1 -: 8];
	assign out_green = q_out[DW-9 -: 8];
	assign out_blue  = q_out[DW-17 -: 8];
	assign dest_x    = q_out[LW +: CW];
	assign dest_y    = q_out[LW-1:0];

	// checks
	`RCS_ASSERT_NOW(a_queue_no_overflow, clk, arst_n, res_valid, fifo_count < OQ_CNT_W'(OQ_DEPTH), "result pushed into a full output queue")
	`RCS_ASSERT_NOW(a_credit_bound, clk, arst_n, 1'b1, credit <= CRW'(OQ_DEPTH), "in-flight results exceed output queue space")
	`RCS_ASSERT_NOW(a_col_in_store, clk, arst_n, 1'b1, 32'(col_q) < MAX_WIDTH, "column counter beyond line store depth")
	`RCS_ASSERT_NEXT(a_push_shows, clk, arst_n, res_valid, out_valid, "pushed result not presented")

endmodule

[rtl/rcs_line_store.sv]
// Two-line pixel store: one synchronous RAM, one read and one write port.
module rcs_line_store #(
	parameter int DEPTH = 1024,
	parameter int DW    = 48,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data
);

	logic [DW-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[rtl/rcs_filter.sv]
// 3x3 window, kernel sums and per-channel saturation.
module rcs_filter #(
	parameter int CW = 10,
	parameter int LW = 12
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  rcs_pkg::stage_ctl_t   col_ctl,
	input  rcs_pkg::pixel_t       col_up,
	input  rcs_pkg::pixel_t       col_mid,
	input  rcs_pkg::pixel_t       col_px,
	input  logic [CW-1:0]         col_dx,
	input  logic [LW-1:0]         col_dy,
	input  logic                  sharpen,
	output logic                  res_valid,
	output rcs_pkg::pixel_t       res_pix,
	output logic [CW-1:0]         res_dx,
	output logic [LW-1:0]         res_dy,
	output rcs_pkg::filt_status_t status
);

	import rcs_pkg::*;

	localparam int SUM_W = 14;

	// kernel sum of one channel; taps in row-major order, centre at 4
	function automatic logic signed [SUM_W-1:0] kernel_sum(input logic [8:0][7:0] t,
		input logic shp);
		logic [9:0]       corner;
		logic [9:0]       edge_sum;
		logic [SUM_W-1:0] acc;
		corner   = 10'(t[0]) + 10'(t[2]) + 10'(t[6]) + 10'(t[8]);
		edge_sum = 10'(t[1]) + 10'(t[3]) + 10'(t[5]) + 10'(t[7]);
		if (shp) begin
			acc = {3'b0, t[4], 3'b0} + {6'b0, t[4]} - SUM_W'(corner) - SUM_W'(edge_sum);
		end else begin
			acc = SUM_W'(corner) + {3'b0, edge_sum, 1'b0} + {4'b0, t[4], 2'b0};
		end
		return $signed(acc);
	endfunction

	// scale, take magnitude and clip to a byte
	function automatic logic [7:0] sat_chan(input logic signed [SUM_W-1:0] s,
		input logic shp);
		logic [SUM_W-1:0] mag;
		mag = s[SUM_W-1] ? SUM_W'(-s) : SUM_W'(s);
		if (!shp) begin
			mag = mag >> 4;
		end
		return (mag > SUM_W'(255)) ? 8'hFF : mag[7:0];
	endfunction

	pixel_t win_q [3][3];
	logic             emit_s2, emit_s3;
	logic [CW-1:0]    dx_s2, dx_s3;
	logic [LW-1:0]    dy_s2, dy_s3;
	logic [8:0][7:0]  tap_r, tap_g, tap_b;
	logic signed [SUM_W-1:0] sum_r_s3, sum_g_s3, sum_b_s3;

	// window shift: oldest column on the left, new column enters on the right
	always_ff @(posedge clk) begin
		if (col_ctl.valid) begin
			win_q[0][0] <= win_q[0][1];
			win_q[0][1] <= win_q[0][2];
			win_q[0][2] <= col_up;
			win_q[1][0] <= win_q[1][1];
			win_q[1][1] <= win_q[1][2];
			win_q[1][2] <= col_mid;
			win_q[2][0] <= win_q[2][1];
			win_q[2][1] <= win_q[2][2];
			win_q[2][2] <= col_px;
			dx_s2 <= col_dx;
			dy_s2 <= col_dy;
		end
	end

	// flatten the window per channel
	for (genvar r = 0; r < 3; r++) begin : g_row
		for (genvar c = 0; c < 3; c++) begin : g_col
			assign tap_r[r*3+c] = win_q[r][c].red;
			assign tap_g[r*3+c] = win_q[r][c].green;
			assign tap_b[r*3+c] = win_q[r][c].blue;
		end
	end

	// stage 3: registered kernel sums
	always_ff @(posedge clk) begin
		if (emit_s2) begin
			sum_r_s3 <= kernel_sum(tap_r, sharpen);
			sum_g_s3 <= kernel_sum(tap_g, sharpen);
			sum_b_s3 <= kernel_sum(tap_b, sharpen);
			dx_s3    <= dx_s2;
			dy_s3    <= dy_s2;
		end
	end

	// stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_s2 <= 1'b0;
			emit_s3 <= 1'b0;
		end else begin
			emit_s2 <= col_ctl.valid & col_ctl.emit;
			emit_s3 <= emit_s2;
		end
	end

	// saturation into the result beat
	assign res_valid     = emit_s3;
	assign res_pix.red   = sat_chan(sum_r_s3, sharpen);
	assign res_pix.green = sat_chan(sum_g_s3, sharpen);
	assign res_pix.blue  = sat_chan(sum_b_s3, sharpen);
	assign res_dx        = dx_s3;
	assign res_dy        = dy_s3;

	assign status.emit_s2 = emit_s2;
	assign status.emit_s3 = emit_s3;

endmodule

[rtl/rcs_out_queue.sv]
// Output queue of result beats, decoupling the pipeline from the receiver.
module rcs_out_queue #(
	parameter int DW = 46
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  logic [DW-1:0]                push_data,
	input  logic                         pop,
	output logic [DW-1:0]                pop_data,
	output logic                         not_empty,
	output logic [rcs_pkg::OQ_CNT_W-1:0] count
);

	import rcs_pkg::*;

	logic [DW-1:0]    q_mem [OQ_DEPTH];
	logic [OQ_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [OQ_CNT_W-1:0] count_q;

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + OQ_CNT_W'(push) - OQ_CNT_W'(pop);
		end
	end

	assign pop_data  = q_mem[rd_ptr_q];
	assign not_empty = (count_q != '0);
	assign count     = count_q;

endmodule

[dv/tb_top.sv]
// Self-checking testbench of the streaming 3x3 RGB smoothing / sharpening filter.
`timescale 1ns / 100ps

module tb_top;
	import rcs_pkg::*;

	localparam int MAX_W        = 1024;
	localparam int MAX_H        = 4096;
	localparam int CW           = 10;
	localparam int LW           = 12;
	localparam int IDLE_PCT     = 23;
	localparam int HOLD_CYCLES  = 300;
	localparam int TAIL_CYCLES  = 8;
	localparam int DRAIN_LIMIT  = 5000;
	localparam int MAX_REPORTED = 10;
	localparam int RANDOM_PIXELS = 600;
	localparam int TALL_LINES   = 12;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef enum {CH_RED, CH_GREEN, CH_BLUE} channel_t;

	typedef struct packed {
		pixel_t          px;
		logic [CW-1:0]   x;
		logic [LW-1:0]   y;
	} filtered_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [7:0] in_red = '0;
	logic [7:0] in_green = '0;
	logic [7:0] in_blue = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [7:0] out_red;
	logic [7:0] out_green;
	logic [7:0] out_blue;
	logic [CW-1:0] dest_x;
	logic [LW-1:0] dest_y;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// filter state as the block should hold it
	logic [MODE_W-1:0]       mode_reg   = MODE_RESET;
	logic [WIDTH_REG_W-1:0]  width_reg  = IMAGE_WIDTH_RESET;
	logic [HEIGHT_REG_W-1:0] height_reg = IMAGE_HEIGHT_RESET;
	pixel_t store_upper [MAX_W];
	pixel_t store_middle [MAX_W];
	pixel_t win [9];
	logic [CW-1:0] col_cnt = '0;
	logic [LW-1:0] line_cnt = '0;

	filtered_t expected_pixels[$];
	int mismatches = 0;
	int pixels_sent = 0;
	int idle_pct = IDLE_PCT;
	bit hold_request = 1'b0;
	int hold_left = 0;

	rgb_conv3x3_smooth_sharpen_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_red    (in_red),
		.in_green  (in_green),
		.in_blue   (in_blue),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_red   (out_red),
		.out_green (out_green),
		.out_blue  (out_blue),
		.dest_x    (dest_x),
		.dest_y    (dest_y),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		foreach (store_upper[i]) begin
			store_upper[i] = '0;
			store_middle[i] = '0;
		end
		foreach (win[i]) win[i] = '0;
	end

	function automatic int eff_width();
		if (width_reg < MIN_DIM) return MIN_DIM;
		if (width_reg > MAX_W) return MAX_W;
		return int'(width_reg);
	endfunction

	function automatic int eff_height();
		if (height_reg < MIN_DIM) return MIN_DIM;
		if (height_reg > MAX_H) return MAX_H;
		return int'(height_reg);
	endfunction

	// one channel of the window through the selected kernel
	function automatic logic [7:0] convolve_channel(channel_t ch, bit sharpen);
		int acc;
		int c;
		int coef;
		acc = 0;
		for (int k = 0; k < 9; k++) begin
			case (ch)
				CH_RED:   c = int'(win[k].red);
				CH_GREEN: c = int'(win[k].green);
				default:  c = int'(win[k].blue);
			endcase
			if (sharpen)
				coef = (k == 4) ? 9 : -1;
			else
				coef = (k == 4) ? 4 : ((k % 2) ? 2 : 1);
			acc += c * coef;
		end
		// Gaussian sum is never negative, so the divide is a plain shift
		if (!sharpen) acc = acc / 16;
		if (acc < 0) acc = -acc;
		if (acc > 255) acc = 255;
		return acc[7:0];
	endfunction

	// move the raster position on by one pixel, queueing the filtered pixel if due
	task automatic advance_raster(input pixel_t px);
		int w;
		int h;
		pixel_t above;
		pixel_t mid;
		filtered_t res;
		bit sharpen;
		w = eff_width();
		h = eff_height();
		above = store_upper[col_cnt];
		mid = store_middle[col_cnt];
		store_upper[col_cnt] = mid;
		store_middle[col_cnt] = px;
		for (int r = 0; r < 3; r++) begin
			win[r*3] = win[r*3+1];
			win[r*3+1] = win[r*3+2];
		end
		win[2] = above;
		win[5] = mid;
		win[8] = px;
		if (col_cnt >= 2 && line_cnt >= 2 && col_cnt < w && line_cnt < h) begin
			sharpen = (mode_reg == MODE_SHARPEN);
			res.px.red = convolve_channel(CH_RED, sharpen);
			res.px.green = convolve_channel(CH_GREEN, sharpen);
			res.px.blue = convolve_channel(CH_BLUE, sharpen);
			res.x = col_cnt - CW'(WIN_LAG);
			res.y = line_cnt - LW'(WIN_LAG);
			expected_pixels.push_back(res);
		end
		// counters may sit past the limits after a register write
		if (col_cnt >= w - 1) begin
			col_cnt = '0;
			if (line_cnt >= h - 1)
				line_cnt = '0;
			else
				line_cnt = line_cnt + 1'b1;
		end else begin
			col_cnt = col_cnt + 1'b1;
		end
	endtask

	// receiver: stalls at random or for a requested hold, checks every beat taken
	always @(posedge clk) begin
		filtered_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_pixels.size() == 0) begin
				if (mismatches < MAX_REPORTED)
					$display("%0t: unexpected beat rgb=%h,%h,%h at (%0d,%0d)",
						$realtime, out_red, out_green, out_blue, dest_x, dest_y);
				mismatches++;
			end else begin
				e = expected_pixels.pop_front();
				if ({out_red, out_green, out_blue} !== e.px || dest_x !== e.x ||
						dest_y !== e.y) begin
					if (mismatches < MAX_REPORTED)
						$display("%0t: mismatch exp rgb=%h,%h,%h (%0d,%0d) got rgb=%h,%h,%h (%0d,%0d)",
							$realtime, e.px.red, e.px.green, e.px.blue, e.x, e.y,
							out_red, out_green, out_blue, dest_x, dest_y);
					mismatches++;
				end
			end
		end
		if (hold_request) begin
			hold_left = HOLD_CYCLES;
			hold_request = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < idle_pct);
		end
	end

	// one register write; valid stays high when another write follows
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data, input bit more);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_FILTER_MODE:  mode_reg = data[MODE_W-1:0];
			REG_IMAGE_WIDTH:  width_reg = data[WIDTH_REG_W-1:0];
			REG_IMAGE_HEIGHT: height_reg = data[HEIGHT_REG_W-1:0];
			default: ; // index past the register list is dropped
		endcase
		if (!more) cfg_valid <= 1'b0;
	endtask

	// one pixel beat, with random gaps ahead of it
	task automatic send_pixel(input pixel_t px);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_red <= px.red;
		in_green <= px.green;
		in_blue <= px.blue;
		do @(posedge clk); while (in_stall);
		advance_raster(px);
		pixels_sent++;
	endtask

	// channels lean towards 0 and 255 to reach saturation often
	function automatic pixel_t random_pixel();
		pixel_t p;
		logic [7:0] ch [3];
		for (int i = 0; i < 3; i++) begin
			case ($urandom_range(9))
				0:       ch[i] = 8'h00;
				1:       ch[i] = 8'hFF;
				default: ch[i] = 8'($urandom_range(255));
			endcase
		end
		p.red = ch[0];
		p.green = ch[1];
		p.blue = ch[2];
		return p;
	endfunction

	// stop sending and let every queued result and in-flight pixel clear
	task automatic wait_drained();
		int guard;
		in_valid <= 1'b0;
		guard = 0;
		while (expected_pixels.size() != 0 && guard < DRAIN_LIMIT) begin
			@(posedge clk);
			guard++;
		end
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_pixels.size() != 0) begin
			if (mismatches < MAX_REPORTED)
				$display("%0t: %0d results never arrived", $realtime, expected_pixels.size());
			mismatches += expected_pixels.size();
			expected_pixels.delete();
		end
	endtask

	task automatic finish_frame();
		while (col_cnt != 0 || line_cnt != 0) send_pixel(random_pixel());
	endtask

	// 3x3 frame from clamped zero sizes, Gaussian via mode 2
	task automatic test_smallest_frame_smooth();
		pixel_t px;
		wait_drained();
		write_reg(REG_FILTER_MODE, 13'd2, 1'b1);
		write_reg(REG_IMAGE_WIDTH, 13'd0, 1'b1);
		write_reg(REG_IMAGE_HEIGHT, 13'd0, 1'b0);
		for (int k = 0; k < 9; k++) begin
			px.red = 8'hFF;
			px.green = (k % 2 == 0 && k != 4) ? 8'hFF : 8'h00;
			px.blue = (k == 4) ? 8'hFF : 8'h00;
			send_pixel(px);
		end
	endtask

	// positive and negative overflow and a small negative sum; unused index ignored
	task automatic test_sharpen_limits();
		pixel_t px;
		wait_drained();
		write_reg(REG_FILTER_MODE, 13'h0005, 1'b1);
		write_reg(REG_UNUSED, 13'h1FFF, 1'b0);
		for (int k = 0; k < 9; k++) begin
			px.red = (k == 4) ? 8'h00 : 8'hFF;
			px.green = (k == 4) ? 8'hFF : 8'h00;
			px.blue = (k == 4) ? 8'h00 : 8'd10;
			send_pixel(px);
		end
	endtask

	// width register all ones, held to the widest line; narrowed once the second line starts
	task automatic test_widest_line();
		wait_drained();
		write_reg(REG_FILTER_MODE, 13'h1FFC, 1'b1);
		write_reg(REG_IMAGE_WIDTH, 13'h1FFF, 1'b1);
		write_reg(REG_IMAGE_HEIGHT, 13'd3, 1'b0);
		repeat (eff_width() + 2) send_pixel(random_pixel());
		// the last line only filters right if the line count moved on at the widest line
		wait_drained();
		write_reg(REG_IMAGE_WIDTH, 13'd3, 1'b0);
		finish_frame();
	endtask

	// height register all ones, held to the tallest frame, on narrow lines
	task automatic test_tallest_frame();
		wait_drained();
		write_reg(REG_FILTER_MODE, 13'd1, 1'b1);
		write_reg(REG_IMAGE_WIDTH, 13'd3, 1'b1);
		write_reg(REG_IMAGE_HEIGHT, 13'h1FFF, 1'b0);
		repeat (TALL_LINES * eff_width()) send_pixel(random_pixel());
		// the line count now sits past the last line, so the next line closes the frame
		wait_drained();
		write_reg(REG_IMAGE_HEIGHT, 13'd3, 1'b0);
		finish_frame();
	endtask

	// shrink width and height under the running counters
	task automatic test_counters_past_limit();
		wait_drained();
		write_reg(REG_FILTER_MODE, 13'd0, 1'b1);
		write_reg(REG_IMAGE_WIDTH, 13'd5, 1'b1);
		write_reg(REG_IMAGE_HEIGHT, 13'd100, 1'b0);
		repeat (19) send_pixel(random_pixel());
		// column 4 is now past the last column
		wait_drained();
		write_reg(REG_IMAGE_WIDTH, 13'd3, 1'b0);
		send_pixel(random_pixel());
		// line 4 is now past the last line
		wait_drained();
		write_reg(REG_IMAGE_HEIGHT, 13'd3, 1'b0);
		repeat (3) send_pixel(random_pixel());
		// a fresh frame only filters right if the counters wrapped
		repeat (9) send_pixel(random_pixel());
	endtask

	// long receiver hold fills the output queue; then a full drain mid-frame
	task automatic test_output_backpressure();
		wait_drained();
		write_reg(REG_FILTER_MODE, 13'd1, 1'b1);
		write_reg(REG_IMAGE_WIDTH, 13'd8, 1'b1);
		write_reg(REG_IMAGE_HEIGHT, 13'd8, 1'b0);
		hold_request = 1'b1;
		repeat (40) send_pixel(random_pixel());
		wait_drained();
		repeat (24) send_pixel(random_pixel());
	endtask

	// random frame sizes and modes, some frames cut by a register change
	task automatic test_random_frames();
		int start;
		int frame;
		int w;
		int h;
		int cut;
		start = pixels_sent;
		frame = 0;
		while (pixels_sent - start < RANDOM_PIXELS) begin
			// a run of frames with neither side idling
			idle_pct = (frame >= 6 && frame < 12) ? 0 : IDLE_PCT;
			if (frame == 0 || $urandom_range(1)) begin
				wait_drained();
				write_reg(REG_FILTER_MODE, CFG_DATA_W'($urandom()), 1'b1);
				write_reg(REG_IMAGE_WIDTH,
					CFG_DATA_W'(($urandom_range(7) == 0) ? $urandom_range(21, 80) :
						$urandom_range(0, 20)),
					1'b1);
				write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'($urandom_range(0, 9)), 1'b0);
			end
			w = eff_width();
			h = eff_height();
			cut = ($urandom_range(3) == 0) ? $urandom_range(1, w * h - 1) : w * h;
			repeat (cut) send_pixel(random_pixel());
			if (cut < w * h) begin
				// only narrowing is safe mid-frame: wider lines would read unwritten stores
				wait_drained();
				write_reg(REG_FILTER_MODE, CFG_DATA_W'($urandom()), 1'b1);
				write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'($urandom_range(0, w)), 1'b1);
				write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'($urandom_range(0, 12)), 1'b0);
				finish_frame();
			end
			frame++;
		end
		idle_pct = IDLE_PCT;
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_smallest_frame_smooth();
		test_sharpen_limits();
		test_widest_line();
		test_tallest_frame();
		test_counters_past_limit();
		test_output_backpressure();
		test_random_frames();
		wait_drained();
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// watchdog
	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end

endmodule
